// ===== design/sgf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SYN-gated flow filter package
// Shared constants and entry layout for the SYN-gated TCP flow filter.
// ----------------------------------------------------------------------------
package sgf_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 4096;
   localparam int DEFAULT_PROBE_LIMIT = 8;

   localparam logic [7:0]  PROTO_TCP    = 8'd6;
   localparam int          FLAG_SYN_BIT = 1;
   localparam int          FLAG_ACK_BIT = 4;
   localparam logic [31:0] CRC32C_POLY  = 32'h82F6_3B78;

   // One table entry: valid bit, {src_ip, dst_ip}, {sport, dport}
   typedef struct packed {
      logic        valid;
      logic [63:0] addr_key;
      logic [31:0] port_key;
   } flow_entry_type;

endpackage
`default_nettype wire

// ===== design/sgf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SYN-gated flow filter channels
// Valid/ready channels for packet headers in and filter verdicts out.
// ----------------------------------------------------------------------------
interface sgf_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] src_ip;
   logic [31:0] dst_ip;
   logic [15:0] sport;
   logic [15:0] dport;
   logic [7:0]  proto;
   logic [7:0]  tcp_flags;

   modport source (output valid, src_ip, dst_ip, sport, dport, proto, tcp_flags,
                   input ready);
   modport sink   (input valid, src_ip, dst_ip, sport, dport, proto, tcp_flags,
                   output ready);
endinterface

interface sgf_rsp_if;
   logic valid;
   logic ready;
   logic keep;
   logic learned;
   logic table_full;

   modport source (output valid, keep, learned, table_full, input ready);
   modport sink   (input valid, keep, learned, table_full, output ready);
endinterface
`default_nettype wire

// ===== design/sgf_flow_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flow hash unit
// CRC32C over the five header words, one word per cycle, then reduction of
// the CRC to a table slot (mask, or reciprocal multiply and one correction
// step otherwise).
// ----------------------------------------------------------------------------
module sgf_flow_hash #(
   parameter int TABLE_DEPTH = sgf_pkg::DEFAULT_TABLE_DEPTH,
   localparam int ADDR_W = $clog2(TABLE_DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [31:0]       src_ip,
   input  wire logic [31:0]       dst_ip,
   input  wire logic [15:0]       sport,
   input  wire logic [15:0]       dport,
   input  wire logic [7:0]        proto,
   output logic                   done,
   output logic [ADDR_W-1:0]      home
);

   localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

   // floor(2^(32+ADDR_W) / TABLE_DEPTH); fits 33 bits since the depth
   // exceeds 2^(ADDR_W-1). The quotient estimate is low by at most one.
   localparam logic [32:0] RECIP    = 33'((64'd1 << (32 + ADDR_W)) / 64'(TABLE_DEPTH));
   localparam logic [31:0] DEPTH_32 = 32'(TABLE_DEPTH);

   localparam logic [2:0] H_IDLE = 3'd0;
   localparam logic [2:0] H_CRC  = 3'd1;
   localparam logic [2:0] H_MUL  = 3'd2;
   localparam logic [2:0] H_SUB  = 3'd3;
   localparam logic [2:0] H_FIX  = 3'd4;

   localparam logic [2:0] W_SRC_IP = 3'd0;
   localparam logic [2:0] W_DST_IP = 3'd1;
   localparam logic [2:0] W_SPORT  = 3'd2;
   localparam logic [2:0] W_DPORT  = 3'd3;
   localparam logic [2:0] W_PROTO  = 3'd4;

   logic [2:0]        state_ff;
   logic [2:0]        word_ff;
   logic [31:0]       crc_ff;
   logic [31:0]       crc_in;
   logic [31:0]       word_sel;
   logic [64:0]       prod_in;
   logic [31:0]       quo_ff;
   logic [31:0]       quo_in;
   logic [31:0]       rem_ff;
   logic [31:0]       rem_in;
   logic [31:0]       fix_in;
   logic              done_ff;
   logic [ADDR_W-1:0] home_ff;

   function automatic logic [31:0] crc32c_word(input logic [31:0] crc,
                                               input logic [31:0] word);
      logic [31:0] c;
      c = crc ^ word;
      for (int b = 0; b < 32; b++) begin
         c = c[0] ? ((c >> 1) ^ sgf_pkg::CRC32C_POLY) : (c >> 1);
      end
      return c;
   endfunction

   always_comb begin
      case (word_ff)
         W_SRC_IP: word_sel = src_ip;
         W_DST_IP: word_sel = dst_ip;
         W_SPORT:  word_sel = {16'd0, sport};
         W_DPORT:  word_sel = {16'd0, dport};
         W_PROTO:  word_sel = {24'd0, proto};
         default:  word_sel = 32'd0;
      endcase
   end

   assign crc_in  = crc32c_word(crc_ff, word_sel);
   assign prod_in = 65'(crc_ff) * 65'(RECIP);
   assign quo_in  = 32'(prod_in >> (32 + ADDR_W));
   assign rem_in  = crc_ff - quo_ff * DEPTH_32;
   assign fix_in  = (rem_ff >= DEPTH_32) ? rem_ff - DEPTH_32 : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            H_IDLE: begin
               if (start) begin
                  crc_ff   <= 32'd0;
                  word_ff  <= W_SRC_IP;
                  state_ff <= H_CRC;
               end
            end
            H_CRC: begin
               crc_ff  <= crc_in;
               word_ff <= word_ff + 3'd1;
               if (word_ff == W_PROTO) begin
                  if (IS_POW2) begin
                     home_ff  <= crc_in[ADDR_W-1:0];
                     done_ff  <= 1'b1;
                     state_ff <= H_IDLE;
                  end else begin
                     state_ff <= H_MUL;
                  end
               end
            end
            H_MUL: begin
               quo_ff   <= quo_in;
               state_ff <= H_SUB;
            end
            H_SUB: begin
               rem_ff   <= rem_in;
               state_ff <= H_FIX;
            end
            H_FIX: begin
               home_ff  <= fix_in[ADDR_W-1:0];
               done_ff  <= 1'b1;
               state_ff <= H_IDLE;
            end
            default: state_ff <= H_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign home = home_ff;

endmodule
`default_nettype wire

// ===== design/syn_gated_tcp_flow_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SYN-gated TCP flow filter core
// Passes non-TCP packets, TCP packets of known flows and opening SYNs, whose
// flow it learns if the window has room; drops other TCP of unknown flows.
// ----------------------------------------------------------------------------
// One item is one parsed packet header; each item yields exactly one verdict
// item (keep, learned, table_full). The flow table is a single memory of
// TABLE_DEPTH entries, each holding a valid bit and the 96-bit flow key, with
// a registered read port. After reset a clearing pass writes every entry
// invalid, one entry per cycle, and the block takes no item until the pass
// is done. The block handles one item at a time. A non-TCP item goes from
// accept straight to the decision step. A TCP item runs CRC32C over the five
// header words (one header word per cycle), then slot reduction when
// TABLE_DEPTH is not a power of two, loads the home slot, probes PROBE_LIMIT
// entries through the single memory read port (one read per cycle, the last
// entry checked after its read returns, then the walk closes), and ends with
// decision and write-back. A verdict waits in an output register, so the
// next item is accepted while the last verdict is still pending; only the
// decision step stalls on a full output.
// ----------------------------------------------------------------------------
module syn_gated_tcp_flow_filter_core #(
   parameter int TABLE_DEPTH = sgf_pkg::DEFAULT_TABLE_DEPTH,
   parameter int PROBE_LIMIT = sgf_pkg::DEFAULT_PROBE_LIMIT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   sgf_req_if.sink     req_ch,
   sgf_rsp_if.source   rsp_ch
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int PCNT_W = $clog2(PROBE_LIMIT + 1);

   localparam logic [ADDR_W-1:0] LAST_SLOT  = ADDR_W'(TABLE_DEPTH - 1);
   localparam logic [PCNT_W-1:0] PROBE_DONE = PCNT_W'(PROBE_LIMIT);

   // Controller states
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_HASH   = 3'd2;
   localparam logic [2:0] S_PROBE  = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;

   logic [2:0]        state_ff;
   logic [ADDR_W-1:0] clr_ff;

   // Held copy of the accepted header
   logic [31:0] src_ip_ff;
   logic [31:0] dst_ip_ff;
   logic [15:0] sport_ff;
   logic [15:0] dport_ff;
   logic [7:0]  proto_ff;
   logic [7:0]  flags_ff;
   logic        is_tcp_ff;

   // Probe walk
   logic [ADDR_W-1:0] slot_ff;
   logic [ADDR_W-1:0] slot_in;
   logic [PCNT_W-1:0] issue_ff;
   logic              rd_vld_ff;
   logic [ADDR_W-1:0] rd_slot_ff;
   logic              hit_ff;
   logic              have_free_ff;
   logic [ADDR_W-1:0] free_slot_ff;

   // Flow table memory
   sgf_pkg::flow_entry_type flow_mem [TABLE_DEPTH];
   sgf_pkg::flow_entry_type mem_rdata_ff;
   sgf_pkg::flow_entry_type mem_wdata;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic                    mem_rd_en;

   // Output register
   logic rsp_valid_ff;
   logic keep_ff;
   logic learned_ff;
   logic table_full_ff;

   logic accept;
   logic commit;
   logic key_match;
   logic syn_open;
   logic keep_in;
   logic learned_in;
   logic full_in;
   logic hash_done;
   logic [ADDR_W-1:0] hash_home;

   // Accept a header only while the controller waits for work
   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   sgf_flow_hash #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && (req_ch.proto == sgf_pkg::PROTO_TCP)),
      .src_ip   (src_ip_ff),
      .dst_ip   (dst_ip_ff),
      .sport    (sport_ff),
      .dport    (dport_ff),
      .proto    (proto_ff),
      .done     (hash_done),
      .home     (hash_home)
   );

   // Advance the probe slot, wrapping at the end of the table
   assign slot_in   = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   assign mem_rd_en = (state_ff == S_PROBE) && (issue_ff != PROBE_DONE);

   assign key_match = mem_rdata_ff.valid
                      && (mem_rdata_ff.addr_key == {src_ip_ff, dst_ip_ff})
                      && (mem_rdata_ff.port_key == {sport_ff, dport_ff});

   // Verdict: non-TCP and known flows pass; an opening SYN learns or flags full
   assign syn_open = flags_ff[sgf_pkg::FLAG_SYN_BIT] && !flags_ff[sgf_pkg::FLAG_ACK_BIT];

   always_comb begin
      keep_in    = 1'b1;
      learned_in = 1'b0;
      full_in    = 1'b0;
      if (is_tcp_ff && !hit_ff) begin
         if (syn_open) begin
            learned_in = have_free_ff;
            full_in    = !have_free_ff;
         end else begin
            keep_in = 1'b0;
         end
      end
   end

   // Retire the item once the output register is free
   assign commit = (state_ff == S_DECIDE) && (!rsp_valid_ff || rsp_ch.ready);

   // Write port: clearing pass, or insertion of a learned flow
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
      end else if (commit && learned_in) begin
         mem_we    = 1'b1;
         mem_waddr = free_slot_ff;
         mem_wdata = '{valid: 1'b1,
                       addr_key: {src_ip_ff, dst_ip_ff},
                       port_key: {sport_ff, dport_ff}};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         flow_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         mem_rdata_ff <= flow_mem[slot_ff];
      end
   end

   // Hold the header for the whole lookup
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ip_ff <= req_ch.src_ip;
         dst_ip_ff <= req_ch.dst_ip;
         sport_ff  <= req_ch.sport;
         dport_ff  <= req_ch.dport;
         proto_ff  <= req_ch.proto;
         flags_ff  <= req_ch.tcp_flags;
         is_tcp_ff <= (req_ch.proto == sgf_pkg::PROTO_TCP);
      end
   end

   // Main controller
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= mem_rd_en;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_SLOT) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  state_ff <= (req_ch.proto == sgf_pkg::PROTO_TCP) ? S_HASH : S_DECIDE;
               end
            end
            S_HASH: begin
               hit_ff       <= 1'b0;
               have_free_ff <= 1'b0;
               issue_ff     <= '0;
               if (hash_done) begin
                  slot_ff  <= hash_home;
                  state_ff <= S_PROBE;
               end
            end
            S_PROBE: begin
               if (mem_rd_en) begin
                  slot_ff    <= slot_in;
                  rd_slot_ff <= slot_ff;
                  issue_ff   <= issue_ff + 1'b1;
               end
               // Check returned entry; keep the first free slot of the window
               if (rd_vld_ff) begin
                  if (key_match) begin
                     hit_ff <= 1'b1;
                  end
                  if (!mem_rdata_ff.valid && !have_free_ff) begin
                     have_free_ff <= 1'b1;
                     free_slot_ff <= rd_slot_ff;
                  end
               end
               if ((issue_ff == PROBE_DONE) && !rd_vld_ff) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (commit) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         keep_ff       <= keep_in;
         learned_ff    <= learned_in;
         table_full_ff <= full_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.keep       = keep_ff;
   assign rsp_ch.learned    = learned_ff;
   assign rsp_ch.table_full = table_full_ff;

   // Table writes happen only in the clearing pass or at a retiring item
   a_write_window: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR) || commit)
      else $error("flow table written outside clear or retire");

   // Probe reads never share a cycle with a table write
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |-> !mem_we)
      else $error("flow table read and write in the same cycle");

   // Hash results arrive only while the controller waits for them
   a_hash_timing: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == S_HASH))
      else $error("hash done outside hash wait");

   // A learned flow always passes and never reports a full window
   a_verdict: assert property (@(posedge clock) disable iff (reset)
      commit && learned_in |-> keep_in && !full_in && have_free_ff && !hit_ff)
      else $error("inconsistent learn verdict");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SYN-gated TCP flow filter testbench
// Drives parsed packet headers into the filter and checks every verdict item
// against an in-bench flow table model. It covers non-TCP pass-through,
// opening SYNs, known flows, drops of stray TCP packets, probe collisions,
// window wrap at the top of the table and the table-full case. The sender and
// receiver idle at random, and one phase also applies long output back-pressure.
// ----------------------------------------------------------------------------
module tb;

   localparam int DEPTH          = sgf_pkg::DEFAULT_TABLE_DEPTH;
   localparam int PROBES         = sgf_pkg::DEFAULT_PROBE_LIMIT;
   // The limit must outlast the clearing pass after reset, which moves no items.
   localparam int WATCHDOG_LIMIT = 5 * DEPTH;
   localparam int DRAIN_CYCLES   = 64;
   localparam int LONG_HOLD      = 300;
   localparam int CROWD_SPAN     = 16;
   localparam int POOL_MAX       = 256;
   localparam int MAX_PRINTS     = 50;

   localparam logic [7:0] F_SYN      = 8'h01 << sgf_pkg::FLAG_SYN_BIT;
   localparam logic [7:0] F_ACK      = 8'h01 << sgf_pkg::FLAG_ACK_BIT;
   localparam logic [7:0] F_PSH      = 8'h08;
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   typedef struct packed {
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  proto;
      logic [7:0]  tcp_flags;
   } pkt_hdr_type;

   typedef struct packed {
      logic keep;
      logic learned;
      logic table_full;
   } verdict_type;

   logic clock;
   logic reset;

   sgf_req_if req_ch ();
   sgf_rsp_if rsp_ch ();

   syn_gated_tcp_flow_filter_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Flow table as the bench sees it; valid bits start cleared like the block's.
   logic [63:0] known_addr  [DEPTH];
   logic [31:0] known_port  [DEPTH];
   bit          known_valid [DEPTH];

   verdict_type verdict_q [$];   // verdicts owed by the block, oldest first
   pkt_hdr_type flow_pool [$];   // flows opened by the random traffic, for follow-ups

   int error_count = 0;
   int idle_cycles = 0;
   int rsp_hold_req = 0;      // long output stall requested from the receiver
   bit src_idle = 1'b1;
   bit sink_idle = 1'b1;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // ----------------------------------------------------------------------
   // Flow table model
   // ----------------------------------------------------------------------

   // Fold one 32-bit word into a reflected CRC32C, least significant bit first.
   function automatic logic [31:0] crc_fold_word(input logic [31:0] crc,
                                                 input logic [31:0] word);
      logic [31:0] c;
      c = crc ^ word;
      for (int b = 0; b < 32; b++)
         c = c[0] ? ((c >> 1) ^ sgf_pkg::CRC32C_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic int unsigned flow_home_slot(input pkt_hdr_type h);
      logic [31:0] c;
      c = crc_fold_word(32'd0, h.src_ip);
      c = crc_fold_word(c, h.dst_ip);
      c = crc_fold_word(c, {16'd0, h.sport});
      c = crc_fold_word(c, {16'd0, h.dport});
      c = crc_fold_word(c, {24'd0, h.proto});
      return c % 32'(DEPTH);
   endfunction

   // Work out the verdict for one header and learn the flow where it opens.
   function automatic verdict_type filter_verdict(input pkt_hdr_type h);
      verdict_type v;
      int unsigned home;
      int unsigned slot;
      int unsigned free_slot;
      bit          hit;
      bit          have_free;
      v.keep       = 1'b1;
      v.learned    = 1'b0;
      v.table_full = 1'b0;
      hit          = 1'b0;
      have_free    = 1'b0;
      free_slot    = 0;
      if (h.proto == sgf_pkg::PROTO_TCP) begin
         home = flow_home_slot(h);
         for (int i = 0; i < PROBES; i++) begin
            slot = (home + i) % DEPTH;
            if (known_valid[slot]) begin
               if (known_addr[slot] == {h.src_ip, h.dst_ip} &&
                   known_port[slot] == {h.sport, h.dport})
                  hit = 1'b1;
            end else if (!have_free) begin
               have_free = 1'b1;
               free_slot = slot;
            end
         end
         if (!hit) begin
            if (h.tcp_flags[sgf_pkg::FLAG_SYN_BIT] && !h.tcp_flags[sgf_pkg::FLAG_ACK_BIT]) begin
               if (have_free) begin
                  known_addr[free_slot]  = {h.src_ip, h.dst_ip};
                  known_port[free_slot]  = {h.sport, h.dport};
                  known_valid[free_slot] = 1'b1;
                  v.learned = 1'b1;
               end else begin
                  v.table_full = 1'b1;
               end
            end else begin
               v.keep = 1'b0;
            end
         end
      end
      return v;
   endfunction

   // ----------------------------------------------------------------------
   // Header builders
   // ----------------------------------------------------------------------

   function automatic pkt_hdr_type make_hdr(input logic [31:0] sip, input logic [31:0] dip,
                                            input logic [15:0] sp, input logic [15:0] dp,
                                            input logic [7:0] pr, input logic [7:0] fl);
      pkt_hdr_type h;
      h.src_ip    = sip;
      h.dst_ip    = dip;
      h.sport     = sp;
      h.dport     = dp;
      h.proto     = pr;
      h.tcp_flags = fl;
      return h;
   endfunction

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic pkt_hdr_type random_flow();
      return make_hdr($urandom, $urandom, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), sgf_pkg::PROTO_TCP, 8'h00);
   endfunction

   // Pick flows that land at the bottom of the table, so probe windows overlap
   // and eventually fill.
   function automatic pkt_hdr_type crowded_flow();
      pkt_hdr_type h;
      h = random_flow();
      while (flow_home_slot(h) >= CROWD_SPAN)
         h = random_flow();
      return h;
   endfunction

   // SYN set, ACK clear, all other flag bits random.
   function automatic logic [7:0] opening_flags();
      return (random_byte() | F_SYN) & ~F_ACK;
   endfunction

   // ----------------------------------------------------------------------
   // Channel handling
   // ----------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("tb: mismatch at %0t ns: %s", $time, what);
   endtask

   // Offer one header after a random gap; predict its verdict once accepted.
   // Valid stays high into the next item when that item draws no gap.
   task automatic send_hdr(input pkt_hdr_type h);
      int gap;
      gap = src_idle ? $urandom_range(0, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.src_ip    <= h.src_ip;
      req_ch.dst_ip    <= h.dst_ip;
      req_ch.sport     <= h.sport;
      req_ch.dport     <= h.dport;
      req_ch.proto     <= h.proto;
      req_ch.tcp_flags <= h.tcp_flags;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      verdict_q.push_back(filter_verdict(h));
   endtask

   // Stop offering and hold until every owed verdict has come back.
   task automatic wait_verdicts_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (verdict_q.size() != 0)
         @(posedge clock);
   endtask

   // Receiver: draw a wait after each verdict item, and honor a long hold when
   // one is requested. Ready changes only at the falling edge.
   initial begin : verdict_sink
      int gap;
      int hold;
      gap  = 0;
      hold = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            gap = sink_idle ? $urandom_range(0, 8) : 0;
         @(negedge clock);
         if (rsp_hold_req > 0) begin
            hold = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            gap--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare each verdict item with the oldest one owed.
   always @(posedge clock) begin : verdict_check
      verdict_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (verdict_q.size() == 0) begin
            report_mismatch("verdict item with no packet waiting");
         end else begin
            want = verdict_q.pop_front();
            if (rsp_ch.keep !== want.keep)
               report_mismatch($sformatf("keep: expected %0b, got %0b",
                                         want.keep, rsp_ch.keep));
            if (rsp_ch.learned !== want.learned)
               report_mismatch($sformatf("learned: expected %0b, got %0b",
                                         want.learned, rsp_ch.learned));
            if (rsp_ch.table_full !== want.table_full)
               report_mismatch($sformatf("table_full: expected %0b, got %0b",
                                         want.table_full, rsp_ch.table_full));
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   // ----------------------------------------------------------------------
   // Tests
   // ----------------------------------------------------------------------

   // Fill the probe window that starts at the last slot, so it wraps to the
   // bottom of the table, then push one more opening SYN into it.
   task automatic test_probe_window_full();
      pkt_hdr_type crowd [$];
      pkt_hdr_type h;
      int unsigned n;
      h = make_hdr(32'hC0A8_0001, 32'h0A00_0001, 16'd0, 16'd0, sgf_pkg::PROTO_TCP, F_SYN);
      n = 0;
      while (crowd.size() < PROBES + 1) begin
         h.sport = n[15:0];
         h.dport = n[31:16];
         if (flow_home_slot(h) == DEPTH - 1)
            crowd.push_back(h);
         n++;
      end
      // First PROBES flows learn; the last one finds the window full but passes.
      foreach (crowd[i])
         send_hdr(crowd[i]);
      // Drop: the overflow flow was never learned.
      h = crowd[PROBES];
      h.tcp_flags = F_ACK;
      send_hdr(h);
      // Keep: the last learned flow sits past the wrap.
      h = crowd[PROBES - 1];
      h.tcp_flags = F_ACK | F_PSH;
      send_hdr(h);
   endtask

   // Non-TCP packets pass with any flags and are never learned.
   task automatic test_non_tcp_pass();
      send_hdr(make_hdr(32'h0, 32'h0, 16'h0, 16'h0, 8'h00, 8'h00));
      send_hdr(make_hdr(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
      send_hdr(make_hdr(32'h0A01_0203, 32'h0A04_0506, 16'd5353, 16'd53, PROTO_UDP, F_SYN));
      // Same key as TCP with ACK: unknown, so drop.
      send_hdr(make_hdr(32'h0A01_0203, 32'h0A04_0506, 16'd5353, 16'd53,
                        sgf_pkg::PROTO_TCP, F_ACK));
   endtask

   // One TCP session from stray packets through opening SYN to traffic.
   task automatic test_tcp_session();
      pkt_hdr_type h;
      h = make_hdr(32'hAC10_0101, 32'hAC10_0202, 16'd40000, 16'd443,
                   sgf_pkg::PROTO_TCP, F_ACK);
      send_hdr(h);                                 // unknown ACK: drop
      h.tcp_flags = F_SYN | F_ACK;
      send_hdr(h);                                 // unknown SYN-ACK: drop
      h.tcp_flags = 8'h00;
      send_hdr(h);                                 // unknown, no flags: drop
      h.tcp_flags = F_SYN;
      send_hdr(h);                                 // opening SYN: learn
      send_hdr(h);                                 // repeated SYN: known, keep
      h.tcp_flags = F_ACK;
      send_hdr(h);                                 // known ACK: keep
      h.tcp_flags = 8'hFF;
      send_hdr(h);                                 // known, all flags: keep
      // Reverse direction is a different flow: drop.
      send_hdr(make_hdr(32'hAC10_0202, 32'hAC10_0101, 16'd443, 16'd40000,
                        sgf_pkg::PROTO_TCP, F_ACK));
      // Opening SYNs at the field extremes.
      send_hdr(make_hdr(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                        sgf_pkg::PROTO_TCP, 8'hFF & ~F_ACK));
      send_hdr(make_hdr(32'h0, 32'h0, 16'h0, 16'h0, sgf_pkg::PROTO_TCP, F_SYN));
   endtask

   // Mostly well-formed sessions with random content, plus noise.
   task automatic test_mixed_traffic(input int count);
      pkt_hdr_type h;
      int unsigned pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            // Open a new flow; some land in the crowded region.
            h = (pick < 6) ? crowded_flow() : random_flow();
            h.tcp_flags = opening_flags();
            flow_pool.push_back(h);
            if (flow_pool.size() > POOL_MAX)
               flow_pool.delete(0);
         end else if (pick < 75 && flow_pool.size() > 0) begin
            // Follow up on an opened flow, mostly with ACK set.
            h = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
            h.tcp_flags = ($urandom_range(0, 3) != 0) ? (random_byte() | F_ACK)
                                                       : random_byte();
         end else if (pick < 88) begin
            // Any protocol, any flags.
            h = random_flow();
            h.proto     = random_byte();
            h.tcp_flags = random_byte();
         end else begin
            // Stray TCP packet of an unknown flow.
            h = random_flow();
            h.tcp_flags = random_byte();
         end
         send_hdr(h);
      end
   endtask

   // Both sides at full rate.
   task automatic test_back_to_back(input int count);
      src_idle  = 1'b0;
      sink_idle = 1'b0;
      test_mixed_traffic(count);
      src_idle  = 1'b1;
      sink_idle = 1'b1;
   endtask

   // Hold the receiver off while the sender keeps offering, so the block fills
   // its output register and stalls its input.
   task automatic test_output_backpressure(input int count);
      src_idle = 1'b0;
      rsp_hold_req = LONG_HOLD;
      test_mixed_traffic(count);
      src_idle = 1'b1;
   endtask

   // Pause the sender until every verdict is back, then resume.
   task automatic test_drain_pause(input int count);
      test_mixed_traffic(count);
      wait_verdicts_drained();
      test_mixed_traffic(count);
   endtask

   // ----------------------------------------------------------------------
   // Sequence
   // ----------------------------------------------------------------------
   initial begin : run
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.src_ip      <= '0;
      req_ch.dst_ip      <= '0;
      req_ch.sport       <= '0;
      req_ch.dport       <= '0;
      req_ch.proto       <= '0;
      req_ch.tcp_flags   <= '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Run the window test first, while the table is still empty.
      test_probe_window_full();
      test_non_tcp_pass();
      test_tcp_session();
      test_mixed_traffic(700);
      test_back_to_back(300);
      test_output_backpressure(60);
      test_drain_pause(40);
      test_mixed_traffic(650);

      // Wait out the verdicts, then a margin for any stray item.
      wait_verdicts_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
